[hdl/glsc_pkg.sv]
// Shared types and constants for the glyph slot LFU cache.
// Used by glsc_ctrl, glsc_dp and glyph_slot_lfu_cache; depends on nothing.
`default_nettype none

package glsc_pkg;

  localparam int unsigned CODE_W    = 16;
  localparam int unsigned CNT_W     = 15;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IDX_OUT_W = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7FFF;
  localparam logic [CNT_W-1:0] COUNT_ONE = 15'h0001;

  localparam logic OP_ACCESS  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNAVAIL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REL     = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  count;
    logic              pin;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic sweep_done;
  } sts_t;

endpackage

`default_nettype wire

[hdl/glsc_ctrl.sv]
// Sequencer for the glyph slot LFU cache: clearing pass, scan, release and result hand-off.
// Depends on glsc_pkg for the command and status structs and the opcode constants.
`default_nettype none

module glsc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_opcode,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output glsc_pkg::cmd_t     cmd,
  input  wire glsc_pkg::sts_t sts
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_REL   = 6'b001000,
    S_UPD   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.clear    = (state_r == S_CLEAR);
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = (in_opcode == glsc_pkg::OP_RELEASE) ? S_REL : S_SCAN;
        end
      end
      S_SCAN, S_REL: begin
        if (sts.sweep_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/glsc_dp.sv]
// Datapath of the glyph slot LFU cache: slot memory, address sweep, hit and victim search.
// Depends on glsc_pkg; driven by glsc_ctrl through the command struct.
`default_nettype none

module glsc_dp #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire glsc_pkg::cmd_t                      cmd,
  output glsc_pkg::sts_t                           sts,
  input  wire logic                                in_opcode,
  input  wire logic [glsc_pkg::CODE_W-1:0]         in_char_code,
  input  wire logic                                in_glyph_available,
  output logic [glsc_pkg::STATUS_W-1:0]            out_status,
  output logic [glsc_pkg::IDX_OUT_W-1:0]           out_slot_index,
  output logic                                     out_evicted_valid,
  output logic [glsc_pkg::CODE_W-1:0]              out_evicted_code
);

  localparam int unsigned AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IDXW = glsc_pkg::IDX_OUT_W;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  glsc_pkg::entry_t mem [SLOTS];

  logic [AW-1:0]    rd_addr_r;
  logic             issue_r;
  logic             rvalid_r;
  logic [AW-1:0]    raddr_r;
  glsc_pkg::entry_t rdata_r;

  logic                        op_r;
  logic [glsc_pkg::CODE_W-1:0] code_r;
  logic                        avail_r;

  logic                       hit_r;
  logic [AW-1:0]              hit_idx_r;
  logic [glsc_pkg::CNT_W-1:0] hit_cnt_r;
  logic                       vstop_r;
  logic [glsc_pkg::CNT_W-1:0] best_r;
  logic [AW-1:0]              vidx_r;
  glsc_pkg::entry_t           vent_r;

  logic [glsc_pkg::STATUS_W-1:0] res_status_r;
  logic [AW-1:0]                 res_idx_r;
  logic                          res_ev_r;
  logic [glsc_pkg::CODE_W-1:0]   res_evc_r;

  logic                       match;
  logic                       cand;
  logic                       scan_beat;
  logic [glsc_pkg::CNT_W-1:0] hit_inc;
  logic                       we;
  logic [AW-1:0]              waddr;
  glsc_pkg::entry_t           wdata;

  assign scan_beat = rvalid_r && (op_r == glsc_pkg::OP_ACCESS);
  assign match     = (rdata_r.count != '0) && (rdata_r.code == code_r);
  assign cand      = !vstop_r && !rdata_r.pin && (rdata_r.count <= best_r);
  assign hit_inc   = (hit_cnt_r == glsc_pkg::COUNT_MAX) ? hit_cnt_r
                                                        : hit_cnt_r + glsc_pkg::COUNT_ONE;

  assign sts.clear_done = cmd.clear && (rd_addr_r == LAST);
  assign sts.sweep_done = rvalid_r && (raddr_r == LAST);

  always_comb begin
    we    = 1'b0;
    waddr = rd_addr_r;
    wdata = '0;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (rvalid_r && (op_r == glsc_pkg::OP_RELEASE)) begin
      we        = 1'b1;
      waddr     = raddr_r;
      wdata     = rdata_r;
      wdata.pin = 1'b0;
    end else if (cmd.update && (op_r == glsc_pkg::OP_ACCESS)) begin
      if (hit_r) begin
        we          = 1'b1;
        waddr       = hit_idx_r;
        wdata.code  = code_r;
        wdata.count = hit_inc;
        wdata.pin   = 1'b1;
      end else if (avail_r) begin
        we          = 1'b1;
        waddr       = vidx_r;
        wdata.code  = code_r;
        wdata.count = glsc_pkg::COUNT_ONE;
        wdata.pin   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue_r) begin
      rdata_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      issue_r   <= 1'b0;
      rvalid_r  <= 1'b0;
    end else begin
      rvalid_r <= issue_r;
      if (cmd.start) begin
        rd_addr_r <= '0;
        issue_r   <= 1'b1;
      end else if (cmd.clear || issue_r) begin
        if (rd_addr_r == LAST) begin
          rd_addr_r <= '0;
          issue_r   <= 1'b0;
        end else begin
          rd_addr_r <= rd_addr_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_r <= rd_addr_r;
    if (cmd.start) begin
      op_r    <= in_opcode;
      code_r  <= in_char_code;
      avail_r <= in_glyph_available;
      hit_r   <= 1'b0;
      vstop_r <= 1'b0;
      best_r  <= glsc_pkg::COUNT_MAX;
      vidx_r  <= '0;
    end else if (scan_beat) begin
      if (match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= raddr_r;
        hit_cnt_r <= rdata_r.count;
      end
      if (cand) begin
        best_r <= rdata_r.count;
        vidx_r <= raddr_r;
        vent_r <= rdata_r;
        if (rdata_r.count == '0) begin
          vstop_r <= 1'b1;
        end
      end else if (raddr_r == '0) begin
        vent_r <= rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_idx_r <= '0;
      res_ev_r  <= 1'b0;
      res_evc_r <= '0;
      if (op_r == glsc_pkg::OP_RELEASE) begin
        res_status_r <= glsc_pkg::ST_REL;
      end else if (hit_r) begin
        res_status_r <= glsc_pkg::ST_HIT;
        res_idx_r    <= hit_idx_r;
      end else if (!avail_r) begin
        res_status_r <= glsc_pkg::ST_UNAVAIL;
      end else begin
        res_status_r <= glsc_pkg::ST_NEW;
        res_idx_r    <= vidx_r;
        if (vent_r.count != '0) begin
          res_ev_r  <= 1'b1;
          res_evc_r <= vent_r.code;
        end
      end
    end
    if (cmd.load_out) begin
      out_status        <= res_status_r;
      out_slot_index    <= IDXW'(res_idx_r);
      out_evicted_valid <= res_ev_r;
      out_evicted_code  <= res_evc_r;
    end
  end

endmodule

`default_nettype wire

[hdl/glyph_slot_lfu_cache.sv]
// Top level of the glyph slot LFU cache: joins the sequencer and the datapath.
// Depends on glsc_pkg, glsc_ctrl and glsc_dp.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | opcode, char_code, glyph_available
//   out_    | output    | out_valid / out_stall | status, slot_index, evicted_valid, evicted_code
//
// Every beat, access or release, makes one pass over the slot memory, one slot read per cycle,
// before its result waits; the next beat is taken only once the previous one has handed its
// result to the output register.
// After reset a clearing pass writes every slot once, with in_stall high.
// A new beat is taken while an earlier result still waits under out_stall; its result
// is held back until the output register is free.
`default_nettype none

module glyph_slot_lfu_cache #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_opcode,
  input  wire logic [glsc_pkg::CODE_W-1:0]         in_char_code,
  input  wire logic                                in_glyph_available,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [glsc_pkg::STATUS_W-1:0]            out_status,
  output logic [glsc_pkg::IDX_OUT_W-1:0]           out_slot_index,
  output logic                                     out_evicted_valid,
  output logic [glsc_pkg::CODE_W-1:0]              out_evicted_code
);

  glsc_pkg::cmd_t cmd;
  glsc_pkg::sts_t sts;

  glsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  glsc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_char_code       (in_char_code),
    .in_glyph_available (in_glyph_available),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_code   (out_evicted_code)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input was not stalled after a beat was accepted.");

  a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.clear_done |=> !in_stall)
    else $error("Block did not go idle after the clearing pass.");

  a_evict_only_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != glsc_pkg::ST_NEW) |->
      !out_evicted_valid && (out_evicted_code == '0))
    else $error("Eviction reported on a result that placed no code.");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == glsc_pkg::ST_UNAVAIL) || (out_status == glsc_pkg::ST_REL))
      |-> (out_slot_index == '0))
    else $error("Slot index not zero on an unavailable or release result.");

endmodule

`default_nettype wire

[dv/glyph_slot_lfu_cache_test.sv]
// Self-checking testbench for glyph_slot_lfu_cache: directed and random glyph requests
// under random idling on both channels, each reply checked against a slot model kept here.
// Depends on glsc_pkg and the glyph_slot_lfu_cache RTL.
`timescale 1ns / 1ps

module glyph_slot_lfu_cache_test;

  localparam int unsigned NUM_SLOTS   = 256;
  localparam int unsigned POOL_SIZE   = 320;
  localparam int unsigned LONG_HOLD   = 3000;
  localparam int unsigned SETTLE      = NUM_SLOTS + 16;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned ST_W        = glsc_pkg::STATUS_W;
  localparam int unsigned IDX_W       = glsc_pkg::IDX_OUT_W;
  localparam int unsigned CODE_W      = glsc_pkg::CODE_W;
  localparam int unsigned CNT_W       = glsc_pkg::CNT_W;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  slot;
    logic              evicted;
    logic [CODE_W-1:0] evicted_code;
  } glyph_reply_t;

  bit                    clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_opcode;
  logic [CODE_W-1:0]     in_char_code;
  logic                  in_glyph_available;
  logic                  out_valid;
  logic                  out_stall;
  logic [ST_W-1:0]       out_status;
  logic [IDX_W-1:0]      out_slot_index;
  logic                  out_evicted_valid;
  logic [CODE_W-1:0]     out_evicted_code;

  logic [CODE_W-1:0]     slot_codes [NUM_SLOTS];
  logic [CNT_W-1:0]      slot_uses  [NUM_SLOTS];
  logic                  slot_pins  [NUM_SLOTS];
  logic [CODE_W-1:0]     code_pool  [POOL_SIZE];
  glyph_reply_t          pending_replies [$];

  int error_count   = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  bit tx_steady     = 1'b0;
  bit rx_steady     = 1'b0;

  glyph_slot_lfu_cache #(
    .SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_char_code       (in_char_code),
    .in_glyph_available (in_glyph_available),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_code   (out_evicted_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 320);
  endfunction

  function automatic glyph_reply_t lookup_glyph(input logic op, input logic [CODE_W-1:0] code,
                                                input logic avail);
    glyph_reply_t     r;
    int               i;
    int               victim;
    logic [CNT_W-1:0] least;
    r = '0;
    if (op == glsc_pkg::OP_RELEASE) begin
      for (i = 0; i < NUM_SLOTS; i++) slot_pins[i] = 1'b0;
      r.status = glsc_pkg::ST_REL;
      return r;
    end
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (slot_uses[i] != '0 && slot_codes[i] == code) begin
        if (slot_uses[i] != glsc_pkg::COUNT_MAX) begin
          slot_uses[i] = slot_uses[i] + glsc_pkg::COUNT_ONE;
        end
        slot_pins[i] = 1'b1;
        r.status = glsc_pkg::ST_HIT;
        r.slot = IDX_W'(i);
        return r;
      end
    end
    if (!avail) begin
      r.status = glsc_pkg::ST_UNAVAIL;
      return r;
    end
    victim = 0;
    if (slot_uses[0] != '0) begin
      least = glsc_pkg::COUNT_MAX;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_pins[i] && slot_uses[i] <= least) begin
          least = slot_uses[i];
          victim = i;
          if (least == '0) break;
        end
      end
    end
    r.status = glsc_pkg::ST_NEW;
    r.slot = IDX_W'(victim);
    r.evicted = (slot_uses[victim] != '0);
    r.evicted_code = r.evicted ? slot_codes[victim] : '0;
    slot_codes[victim] = code;
    slot_uses[victim] = glsc_pkg::COUNT_ONE;
    slot_pins[victim] = 1'b1;
    return r;
  endfunction

  // A beat is taken at a rising edge with valid high and stall low.
  task automatic send_request(input logic op, input logic [CODE_W-1:0] code, input logic avail);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_char_code <= code;
    in_glyph_available <= avail;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(lookup_glyph(op, code, avail));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_request(glsc_pkg::OP_ACCESS, 16'h0000, 1'b0);
    send_request(glsc_pkg::OP_ACCESS, 16'h0000, 1'b1);
    send_request(glsc_pkg::OP_ACCESS, 16'h0000, 1'b0);
    send_request(glsc_pkg::OP_ACCESS, 16'hFFFF, 1'b1);
    send_request(glsc_pkg::OP_RELEASE, 16'hFFFF, 1'b1);
    send_request(glsc_pkg::OP_ACCESS, 16'h1234, 1'b1);
    send_request(glsc_pkg::OP_ACCESS, 16'hFFFF, 1'b0);
    send_request(glsc_pkg::OP_ACCESS, 16'hA5A5, 1'b0);
    send_request(glsc_pkg::OP_RELEASE, 16'h0000, 1'b0);
    send_request(glsc_pkg::OP_ACCESS, 16'h5A5A, 1'b1);
    send_request(glsc_pkg::OP_ACCESS, 16'h1234, 1'b1);
    send_request(glsc_pkg::OP_ACCESS, 16'h5A5A, 1'b1);
    send_request(glsc_pkg::OP_ACCESS, 16'hEDCB, 1'b1);
    wait_for_drain();
  endtask

  // Every placement pins its slot, so past the slot count each miss lands on slot 0.
  task automatic test_fill_all_pinned();
    int n;
    for (n = 0; n < NUM_SLOTS + 16; n++) begin
      send_request(glsc_pkg::OP_ACCESS, 16'($urandom), 1'b1);
    end
    wait_for_drain();
  endtask

  task automatic test_output_backpressure();
    int n;
    tx_steady = 1'b1;
    hold_requests++;
    for (n = 0; n < 8; n++) begin
      send_request(glsc_pkg::OP_ACCESS, code_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b1);
    end
    wait_for_drain();
    tx_steady = 1'b0;
  endtask

  task automatic test_random_traffic(input int count);
    int                n;
    int                roll;
    logic              op;
    logic [CODE_W-1:0] code;
    logic              avail;
    for (n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        op = glsc_pkg::OP_RELEASE;
        code = 16'($urandom);
        avail = 1'($urandom);
      end else begin
        op = glsc_pkg::OP_ACCESS;
        code = (roll < 88) ? code_pool[$urandom_range(0, POOL_SIZE - 1)] : 16'($urandom);
        avail = ($urandom_range(0, 99) < 85);
      end
      send_request(op, code, avail);
      if ($urandom_range(0, 99) == 0) wait_for_drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : receiver_pacing
    int stall_run;
    stall_run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_run = LONG_HOLD;
      end else if (stall_run == 0 && !rx_steady && $urandom_range(0, 99) < 15) begin
        stall_run = pick_gap();
      end
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : reply_checker
    glyph_reply_t want;
    glyph_reply_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_slot_index, out_evicted_valid, out_evicted_code};
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: reply beat with none expected: status %0d slot %0d", $time,
                   got.status, got.slot);
        end
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.evicted !== want.evicted || got.evicted_code !== want.evicted_code) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: reply mismatch: expected status %0d slot %0d evicted %0b code %h",
                     $time, want.status, want.slot, want.evicted, want.evicted_code);
            $display("%0t:                 actual   status %0d slot %0d evicted %0b code %h",
                     $time, got.status, got.slot, got.evicted, got.evicted_code);
          end
        end
      end
    end
  end

  initial begin : test_sequence
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = glsc_pkg::OP_ACCESS;
    in_char_code = '0;
    in_glyph_available = 1'b0;
    foreach (slot_codes[i]) begin
      slot_codes[i] = '0;
      slot_uses[i] = '0;
      slot_pins[i] = 1'b0;
    end
    foreach (code_pool[i]) code_pool[i] = 16'($urandom);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_fill_all_pinned();
    test_output_backpressure();
    test_random_traffic(1400);

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[glyph_slot_lfu_cache.f]
hdl/glsc_pkg.sv
hdl/glsc_ctrl.sv
hdl/glsc_dp.sv
hdl/glyph_slot_lfu_cache.sv
dv/glyph_slot_lfu_cache_test.sv
